// ----- src/bjct_pkg.sv -----
// Shared constants, codes and controller/datapath types for the block jump count table.
// No dependencies; every other file in this block depends on this package.
package bjct_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W   = $clog2(MAX_POSITIONS);
    localparam int CFG_W   = 11;
    localparam int JUMP_W  = 11;
    localparam int TGT_W   = 12;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = CNT_W + 1;
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CFG_W-1:0] MAX_POS_VAL = CFG_W'(MAX_POSITIONS);
    localparam logic [CFG_W-1:0] POS_COUNT_RESET = CFG_W'(1024);
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = CFG_W'(32);

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t REG_POSITION_COUNT = 1'b0;
    localparam cfg_idx_t REG_BLOCK_SIZE     = 1'b1;

    typedef enum logic [0:0] {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic u_setup;
        logic u_read_t;
        logic u_write;
        logic q_start;
        logic q_walk;
        logic load_result;
    } bjct_cmd_t;

    typedef struct packed {
        logic q_in_range;
        logic walk_more;
        logic block_done;
    } bjct_status_t;

endpackage

// ----- src/bjct_req_if.sv -----
// Request channel interface: valid/ready handshake carrying opcode, position and jump.
// Depends on bjct_pkg.
interface bjct_req_if;
    logic                         valid;
    logic                         ready;
    bjct_pkg::opcode_t            opcode;
    logic [bjct_pkg::POS_W-1:0]   position;
    logic [bjct_pkg::JUMP_W-1:0]  jump;

    modport source (output valid, output opcode, output position, output jump, input ready);
    modport sink   (input valid, input opcode, input position, input jump, output ready);
endinterface

// ----- src/bjct_rsp_if.sv -----
// Response channel interface: valid/ready handshake carrying the query jump total.
// Depends on bjct_pkg.
interface bjct_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bjct_pkg::CNT_W-1:0]  jump_total;

    modport source (output valid, output jump_total, input ready);
    modport sink   (input valid, input jump_total, output ready);
endinterface

// ----- src/bjct_ctrl.sv -----
// Controller state machine for the block jump count table.
// Depends on bjct_pkg; drives commands to bjct_datapath and reads its status.
module bjct_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  bjct_pkg::opcode_t      req_opcode,
    output logic                   req_ready,
    input  logic                   rsp_ready,
    output logic                   rsp_valid,
    input  bjct_pkg::bjct_status_t status,
    output bjct_pkg::bjct_cmd_t    cmd
);
    import bjct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_U_SETUP,
        S_U_READT,
        S_U_WRITE,
        S_Q_START,
        S_Q_WALK,
        S_Q_DONE
    } state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept   = 1'b1;
                    div_cnt_next = '0;
                    state_next   = (req_opcode == OP_UPDATE) ? S_DIV : S_Q_START;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_U_SETUP;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_U_SETUP:
            begin
                cmd.u_setup = 1'b1;
                state_next  = S_U_READT;
            end
            S_U_READT:
            begin
                cmd.u_read_t = 1'b1;
                state_next   = S_U_WRITE;
            end
            S_U_WRITE:
            begin
                cmd.u_write = 1'b1;
                state_next  = status.block_done ? S_IDLE : S_U_READT;
            end
            S_Q_START:
            begin
                cmd.q_start = 1'b1;
                state_next  = status.q_in_range ? S_Q_WALK : S_Q_DONE;
            end
            S_Q_WALK:
            begin
                cmd.q_walk = 1'b1;
                if (!status.walk_more)
                begin
                    state_next = S_Q_DONE;
                end
            end
            S_Q_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_result = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/bjct_datapath.sv -----
// Datapath for the block jump count table: configuration registers, the three tables,
// the block-start divider, the rebuild and walk arithmetic. Depends on bjct_pkg.
module bjct_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  bjct_pkg::cfg_idx_t          cfg_index,
    input  logic [bjct_pkg::CFG_W-1:0]  cfg_data,
    input  bjct_pkg::opcode_t           req_opcode,
    input  logic [bjct_pkg::POS_W-1:0]  req_position,
    input  logic [bjct_pkg::JUMP_W-1:0] req_jump,
    input  bjct_pkg::bjct_cmd_t         cmd,
    output bjct_pkg::bjct_status_t      status,
    output logic [bjct_pkg::CNT_W-1:0]  jump_total
);
    import bjct_pkg::*;

    logic [CFG_W-1:0]  pos_count_reg;
    logic [CFG_W-1:0]  block_size_reg;
    logic [CFG_W-1:0]  n_eff;
    logic [CFG_W-1:0]  b_eff;

    logic [JUMP_W-1:0] jump_mem [0:MAX_POSITIONS-1];
    logic [TGT_W-1:0]  exit_mem [0:MAX_POSITIONS-1];
    logic [CNT_W-1:0]  cnt_mem  [0:MAX_POSITIONS-1];

    logic [JUMP_W-1:0] jump_rd_reg;
    logic [TGT_W-1:0]  exit_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  dvd_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [POS_W-1:0]  start_reg;
    logic [CFG_W-1:0]  end_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic [POS_W-1:0]  x_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  result_reg;

    logic [JUMP_W-1:0] jump_fix;
    logic [CFG_W:0]    rem_shift;
    logic              rem_ge;
    logic [CFG_W:0]    rem_sub;
    logic [POS_W-1:0]  start_val;
    logic [TGT_W-1:0]  end_full;
    logic [TGT_W-1:0]  tgt_sum;
    logic              tgt_far;
    logic [TGT_W-1:0]  exit_wdata;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [SUM_W-1:0]  total_sum;
    logic [CNT_W-1:0]  total_sat;
    logic [POS_W-1:0]  jump_raddr;
    logic [POS_W-1:0]  entry_raddr;

    assign n_eff = (pos_count_reg > MAX_POS_VAL) ? MAX_POS_VAL : pos_count_reg;
    assign b_eff = (block_size_reg == '0) ? CFG_W'(1) : block_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_count_reg  <= POS_COUNT_RESET;
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POSITION_COUNT: pos_count_reg  <= cfg_data;
                REG_BLOCK_SIZE:     block_size_reg <= cfg_data;
                default:            pos_count_reg  <= pos_count_reg;
            endcase
        end
    end

    always_comb
    begin
        jump_fix   = (req_jump == '0) ? JUMP_W'(1) : req_jump;
        rem_shift  = {rem_reg, dvd_reg[POS_W-1]};
        rem_ge     = rem_shift >= {1'b0, b_eff};
        rem_sub    = rem_shift - {1'b0, b_eff};
        start_val  = pos_reg - rem_reg[POS_W-1:0];
        end_full   = TGT_W'(start_val) + TGT_W'(b_eff);
        tgt_sum    = TGT_W'(idx_reg) + TGT_W'(jump_rd_reg);
        tgt_far    = tgt_reg >= TGT_W'(end_reg);
        exit_wdata = tgt_far ? tgt_reg : exit_rd_reg;
        if (tgt_far)
        begin
            cnt_wdata = CNT_W'(1);
        end
        else
        begin
            cnt_wdata = (cnt_rd_reg == COUNT_MAX) ? COUNT_MAX : cnt_rd_reg + 1'b1;
        end
        total_sum = SUM_W'(total_reg) + SUM_W'(cnt_rd_reg);
        total_sat = (total_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : total_sum[CNT_W-1:0];
        jump_raddr = cmd.u_setup ? pos_reg : idx_reg - 1'b1;
        if (cmd.q_walk)
        begin
            entry_raddr = exit_rd_reg[POS_W-1:0];
        end
        else if (cmd.u_read_t)
        begin
            entry_raddr = tgt_sum[POS_W-1:0];
        end
        else
        begin
            entry_raddr = pos_reg;
        end
    end

    assign status.q_in_range = CFG_W'(pos_reg) < n_eff;
    assign status.walk_more  = (exit_rd_reg > TGT_W'(x_reg)) && (exit_rd_reg < TGT_W'(n_eff));
    assign status.block_done = idx_reg == start_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req_opcode == OP_UPDATE))
        begin
            jump_mem[req_position] <= jump_fix;
        end
        jump_rd_reg <= jump_mem[jump_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.u_write)
        begin
            exit_mem[idx_reg] <= exit_wdata;
            cnt_mem[idx_reg]  <= cnt_wdata;
        end
        exit_rd_reg <= exit_mem[entry_raddr];
        cnt_rd_reg  <= cnt_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pos_reg <= req_position;
            dvd_reg <= req_position;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[CFG_W-1:0] : rem_shift[CFG_W-1:0];
            dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
        end
        if (cmd.u_setup)
        begin
            start_reg <= start_val;
            end_reg   <= (end_full > TGT_W'(n_eff)) ? n_eff : end_full[CFG_W-1:0];
            idx_reg   <= pos_reg;
        end
        if (cmd.u_read_t)
        begin
            tgt_reg <= tgt_sum;
        end
        if (cmd.u_write && !status.block_done)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.q_start)
        begin
            x_reg     <= pos_reg;
            total_reg <= '0;
        end
        if (cmd.q_walk)
        begin
            total_reg <= total_sat;
            if (status.walk_more)
            begin
                x_reg <= exit_rd_reg[POS_W-1:0];
            end
        end
        if (cmd.load_result)
        begin
            result_reg <= total_reg;
        end
    end

    assign jump_total = result_reg;

endmodule

// ----- src/block_jump_count_table.sv -----
// Block jump count table top level. One transaction is handled at a time.
// Query: accept, start, a walk step for each shortcut hop until the walk leaves the table, and the result load,
// which waits while an earlier response is still held. Update: accept, a 10-step block-start divider and block
// setup, then a target read and a write step for each rebuilt entry (the exit and count tables have one read port).
// Reset restores control and configuration only; table contents are undefined until written.
module block_jump_count_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  bjct_pkg::cfg_idx_t          cfg_index,
    input  logic [bjct_pkg::CFG_W-1:0]  cfg_data,
    bjct_req_if.sink                    req,
    bjct_rsp_if.source                  rsp
);
    import bjct_pkg::*;

    bjct_cmd_t    cmd;
    bjct_status_t status;

    bjct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .status     (status),
        .cmd        (cmd)
    );

    bjct_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_opcode   (req.opcode),
        .req_position (req.position),
        .req_jump     (req.jump),
        .cmd          (cmd),
        .status       (status),
        .jump_total   (rsp.jump_total)
    );

`ifndef NO_ASSERTIONS
    a_update_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.opcode == OP_UPDATE && !rsp.valid) |=> !rsp.valid)
        else $error("An update transaction produced a response.");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.load_result))
        else $error("Response became valid without a result load.");

    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !(cmd.div_step || cmd.u_write || cmd.q_walk || cmd.load_result))
        else $error("Request ready while a transaction is still in progress.");
`endif

endmodule
